// File: design/mwrf_pkg.sv
// ----------------------------------------------------------------------------
// mwrf_pkg
// Shared types, constants and opcodes of the mixed-width register file.
// ----------------------------------------------------------------------------
package mwrf_pkg;

  localparam int          REG_COUNT_DEF = 255;
  localparam int          SPECIAL_COUNT = 14;
  localparam logic [15:0] SP_RESET      = 16'hFFFC;

  localparam int BANK_DEPTH = 128;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);

  localparam logic [2:0] OP_RD_BYTE = 3'd0;
  localparam logic [2:0] OP_WR_BYTE = 3'd1;
  localparam logic [2:0] OP_RD_WORD = 3'd2;
  localparam logic [2:0] OP_WR_WORD = 3'd3;
  localparam logic [2:0] OP_COPY    = 3'd4;
  localparam logic [2:0] OP_SWAP    = 3'd5;
  localparam logic [2:0] OP_CMP     = 3'd6;

  typedef struct packed {
    logic               en;
    logic [BANK_AW-1:0] addr;
    logic [7:0]         data;
  } bank_wr_t;

  function automatic logic [15:0] spec_reset_val(input logic [3:0] idx);
    logic [15:0] v;
    v = (idx == 4'd0) ? SP_RESET : 16'h0000;
    return v;
  endfunction

endpackage

// File: design/mwrf_byte_bank.sv
// ----------------------------------------------------------------------------
// mwrf_byte_bank
// One bank of byte registers: two registered read ports, one write port,
// per-entry valid bits so unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module mwrf_byte_bank import mwrf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rd_en,
  input  logic [BANK_AW-1:0] rd_addr_a,
  input  logic [BANK_AW-1:0] rd_addr_b,
  output logic [7:0]         rd_data_a,
  output logic [7:0]         rd_data_b,
  input  bank_wr_t           wr
);

  logic [7:0]            mem [BANK_DEPTH];
  logic [BANK_DEPTH-1:0] vld_r;
  logic [7:0]            rd_a_r;
  logic [7:0]            rd_b_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= vld_r[rd_addr_a] ? mem[rd_addr_a] : 8'h00;
      rd_b_r <= vld_r[rd_addr_b] ? mem[rd_addr_b] : 8'h00;
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

// File: design/mixed_width_register_file_unit.sv
// ----------------------------------------------------------------------------
// mixed_width_register_file_unit
// Register file with fourteen 16-bit special registers and byte registers
// addressable singly or as big-endian word pairs.
// ----------------------------------------------------------------------------
// One beat is taken when the unit is idle; its result is registered and a new
// beat is taken while that result still waits. For reads, copy, compare and
// plain writes the accept edge issues the registered memory reads and EXEC
// modifies and writes back once the result register is free; swap adds SWAPB,
// as each byte bank has one write port and the two words are written in turn.
// Byte registers sit in even and odd banks so a word is one access to each.
// ----------------------------------------------------------------------------
module mixed_width_register_file_unit import mwrf_pkg::*; #(
  parameter int REG_COUNT = REG_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [7:0]  in_reg_a,
  input  logic [7:0]  in_reg_b,
  input  logic [15:0] in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_read_data,
  output logic        out_equal,
  output logic        out_error
);

  localparam logic [8:0] RC9    = 9'(REG_COUNT);
  localparam logic [7:0] SPC8   = 8'(SPECIAL_COUNT);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_SWAPB = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [2:0]  op_r;
  logic [7:0]  a_r, b_r;
  logic [15:0] d_r;

  logic        out_valid_r;
  logic [15:0] out_read_data_r;
  logic        out_equal_r;
  logic        out_error_r;

  logic        in_acc;
  logic        out_free;
  logic        finish;

  // read address generation at accept
  logic [7:0]         in_a_inc, in_b_inc;
  logic [BANK_AW-1:0] ev_addr_a, ev_addr_b;

  logic [7:0] ev_a, ev_b, od_a, od_b;

  // special register memory
  logic [15:0]              sp_mem [SPECIAL_COUNT];
  logic [SPECIAL_COUNT-1:0] sp_vld_r;
  logic [15:0]              sp_a_r, sp_b_r;
  logic                     sp_we;
  logic [3:0]               sp_waddr;

  // execute stage
  logic        two_op, err;
  logic        a_spec, b_spec, a_lo_ok, b_lo_ok;
  logic [15:0] word_a, word_b;
  logic [7:0]  byte_a;
  logic [15:0] res_rd;
  logic        res_eq;

  // write-back
  logic        wr_go, wr_byte;
  logic [7:0]  wr_idx, wr_idx_inc;
  logic [15:0] wr_val;
  logic        wr_spec, lo_en;
  bank_wr_t    hi_wr, lo_wr, ev_wr, od_wr;

  assign in_acc   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r <= in_op;
      a_r  <= in_reg_a;
      b_r  <= in_reg_b;
      d_r  <= in_data;
    end
  end

  assign in_a_inc  = in_reg_a + 8'd1;
  assign in_b_inc  = in_reg_b + 8'd1;
  assign ev_addr_a = in_reg_a[0] ? in_a_inc[7:1] : in_reg_a[7:1];
  assign ev_addr_b = in_reg_b[0] ? in_b_inc[7:1] : in_reg_b[7:1];

  mwrf_byte_bank u_even (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_acc),
    .rd_addr_a (ev_addr_a),
    .rd_addr_b (ev_addr_b),
    .rd_data_a (ev_a),
    .rd_data_b (ev_b),
    .wr        (ev_wr)
  );

  mwrf_byte_bank u_odd (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_acc),
    .rd_addr_a (in_reg_a[7:1]),
    .rd_addr_b (in_reg_b[7:1]),
    .rd_data_a (od_a),
    .rd_data_b (od_b),
    .wr        (od_wr)
  );

  // special registers
  always_ff @(posedge clk) begin
    if (sp_we) begin
      sp_mem[sp_waddr] <= wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_vld_r <= '0;
    end else if (sp_we) begin
      sp_vld_r[sp_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (in_reg_a < SPC8) begin
        sp_a_r <= sp_vld_r[in_reg_a[3:0]] ? sp_mem[in_reg_a[3:0]]
                                          : spec_reset_val(in_reg_a[3:0]);
      end else begin
        sp_a_r <= 16'h0000;
      end
      if (in_reg_b < SPC8) begin
        sp_b_r <= sp_vld_r[in_reg_b[3:0]] ? sp_mem[in_reg_b[3:0]]
                                          : spec_reset_val(in_reg_b[3:0]);
      end else begin
        sp_b_r <= 16'h0000;
      end
    end
  end

  // operand assembly
  always_comb begin
    unique case (op_r) inside
      OP_COPY, OP_SWAP, OP_CMP: two_op = 1'b1;
      default:                  two_op = 1'b0;
    endcase
    err = (op_r <= OP_CMP) &&
          (({1'b0, a_r} >= RC9) || (two_op && ({1'b0, b_r} >= RC9)));

    a_spec  = a_r < SPC8;
    b_spec  = b_r < SPC8;
    a_lo_ok = ({1'b0, a_r} + 9'd1) < RC9;
    b_lo_ok = ({1'b0, b_r} + 9'd1) < RC9;

    byte_a = a_spec ? sp_a_r[7:0] : (a_r[0] ? od_a : ev_a);
    word_a = a_spec ? sp_a_r
                    : {(a_r[0] ? od_a : ev_a),
                       (a_lo_ok ? (a_r[0] ? ev_a : od_a) : 8'h00)};
    word_b = b_spec ? sp_b_r
                    : {(b_r[0] ? od_b : ev_b),
                       (b_lo_ok ? (b_r[0] ? ev_b : od_b) : 8'h00)};

    res_rd = 16'h0000;
    res_eq = 1'b0;
    if (!err) begin
      case (op_r)
        OP_RD_BYTE: res_rd = {8'h00, byte_a};
        OP_RD_WORD: res_rd = word_a;
        OP_CMP:     res_eq = (word_a == word_b);
        default:    res_rd = 16'h0000;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    finish    = 1'b0;
    wr_go     = 1'b0;
    wr_byte   = 1'b0;
    wr_idx    = a_r;
    wr_val    = d_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!err && op_r == OP_SWAP) begin
          wr_go     = 1'b1;
          wr_val    = word_b;
          state_nxt = ST_SWAPB;
        end else if (out_free) begin
          finish    = 1'b1;
          state_nxt = ST_IDLE;
          if (!err) begin
            unique case (op_r)
              OP_WR_BYTE: begin
                wr_go   = 1'b1;
                wr_byte = 1'b1;
                wr_val  = a_spec ? {word_a[15:8], d_r[7:0]} : {d_r[7:0], 8'h00};
              end
              OP_WR_WORD: begin
                wr_go  = 1'b1;
                wr_val = d_r;
              end
              OP_COPY: begin
                wr_go  = 1'b1;
                wr_val = word_b;
              end
              default: wr_go = 1'b0;
            endcase
          end
        end
      end
      ST_SWAPB: begin
        wr_idx = b_r;
        wr_val = word_a;
        if (out_free) begin
          wr_go     = 1'b1;
          finish    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // write decode: high byte at idx, low byte at idx+1 in the other bank
  always_comb begin
    wr_idx_inc = wr_idx + 8'd1;
    wr_spec    = wr_idx < SPC8;
    sp_we      = wr_go && wr_spec;
    sp_waddr   = wr_idx[3:0];
    lo_en      = wr_go && !wr_spec && !wr_byte && (({1'b0, wr_idx} + 9'd1) < RC9);

    hi_wr.en   = wr_go && !wr_spec;
    hi_wr.addr = wr_idx[7:1];
    hi_wr.data = wr_val[15:8];
    lo_wr.en   = lo_en;
    lo_wr.addr = wr_idx_inc[7:1];
    lo_wr.data = wr_val[7:0];

    ev_wr = wr_idx[0] ? lo_wr : hi_wr;
    od_wr = wr_idx[0] ? hi_wr : lo_wr;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_read_data_r <= res_rd;
      out_equal_r     <= res_eq;
      out_error_r     <= err;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;
  assign out_equal     = out_equal_r;
  assign out_error     = out_error_r;

  // checks
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    finish && out_valid_r |-> out_ready)
    else $error("result overwritten while pending");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_error_r |-> (out_read_data_r == 16'h0000) && !out_equal_r)
    else $error("error beat carries data");

  a_swapb_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ST_SWAPB) |-> $past(state_r) == ST_EXEC && $past(op_r) == OP_SWAP)
    else $error("second swap write without swap");

  a_no_write_on_err: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) && err |-> !wr_go)
    else $error("write on invalid index");

endmodule
